/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// No dependencies; every user provides aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define VTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define VTB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/vtb_pkg.sv */
// Shared widths, register indexes, reset values and types for the vertex
// transform block. No dependencies.
package vtb_pkg;

    // Field widths
    localparam int POS_W    = 32;   // Q16.16 position
    localparam int NRM_W    = 16;   // Q1.14 normal
    localparam int COEF_W   = 16;   // Q3.12 coefficient
    localparam int COEF_FRAC = 12;
    localparam int NUM_AXES = 3;
    localparam int ROW_W    = NUM_AXES * COEF_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = ROW_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_ROW0 = 3'd0,
        CFG_LIN_ROW1 = 3'd1,
        CFG_LIN_ROW2 = 3'd2,
        CFG_TRANS_X  = 3'd3,
        CFG_TRANS_Y  = 3'd4,
        CFG_TRANS_Z  = 3'd5
    } cfg_reg_e;

    // Identity matrix rows after reset
    localparam logic [ROW_W-1:0] LIN_ROW0_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] LIN_ROW1_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] LIN_ROW2_RST = 48'h1000_0000_0000;

    // Control handed to the bounding box lanes
    typedef struct packed {
        logic update;   // a word moves into the result register
        logic first;    // restart the box at this vertex
    } bnd_ctl_t;

endpackage

/* hdl/vtb_row_unit.sv */
// One matrix row: position dot product with rounding, translation and
// saturation, and normal dot product with rounding and saturation. Uses vtb_pkg.
module vtb_row_unit (
    input  logic        [vtb_pkg::ROW_W-1:0] coef_row,
    input  logic signed [vtb_pkg::POS_W-1:0] trans,
    input  logic signed [vtb_pkg::POS_W-1:0] pos [vtb_pkg::NUM_AXES],
    input  logic signed [vtb_pkg::NRM_W-1:0] nrm [vtb_pkg::NUM_AXES],
    output logic signed [vtb_pkg::POS_W-1:0] pos_out,
    output logic signed [vtb_pkg::NRM_W-1:0] nrm_out
);

    localparam int CW   = vtb_pkg::COEF_W;
    localparam int PW   = vtb_pkg::POS_W;
    localparam int NW   = vtb_pkg::NRM_W;
    localparam int FR   = vtb_pkg::COEF_FRAC;
    localparam int PP_W = CW + PW;          // position product
    localparam int PS_W = PP_W + 2;         // sum of three
    localparam int PR_W = PS_W - FR;        // after rescale
    localparam int PO_W = PR_W + 1;         // after translation
    localparam int NP_W = CW + NW;
    localparam int NS_W = NP_W + 2;
    localparam int NR_W = NS_W - FR;

    logic signed [CW-1:0]   coef [vtb_pkg::NUM_AXES];
    logic signed [PP_W-1:0] pos_pp [vtb_pkg::NUM_AXES];
    logic signed [NP_W-1:0] nrm_pp [vtb_pkg::NUM_AXES];
    logic signed [PS_W-1:0] pos_sum;
    logic signed [PS_W-1:0] pos_rnd;
    logic signed [PR_W-1:0] pos_scl;
    logic signed [PO_W-1:0] pos_off;
    logic signed [NS_W-1:0] nrm_sum;
    logic signed [NS_W-1:0] nrm_rnd;
    logic signed [NR_W-1:0] nrm_scl;

    // Per-column products
    always_comb begin
        for (int j = 0; j < vtb_pkg::NUM_AXES; j++) begin
            coef[j]   = coef_row[j*CW +: CW];
            pos_pp[j] = coef[j] * pos[j];
            nrm_pp[j] = coef[j] * nrm[j];
        end
    end

    // Sum, round half up, drop the coefficient fraction
    assign pos_sum = PS_W'(pos_pp[0]) + PS_W'(pos_pp[1]) + PS_W'(pos_pp[2]);
    assign pos_rnd = pos_sum + PS_W'(1 << (FR - 1));
    assign pos_scl = pos_rnd[PS_W-1:FR];
    assign pos_off = PO_W'(pos_scl) + PO_W'(trans);

    assign nrm_sum = NS_W'(nrm_pp[0]) + NS_W'(nrm_pp[1]) + NS_W'(nrm_pp[2]);
    assign nrm_rnd = nrm_sum + NS_W'(1 << (FR - 1));
    assign nrm_scl = nrm_rnd[NS_W-1:FR];

    // Saturate: fits when all bits above the field match the sign
    always_comb begin
        if (pos_off[PO_W-1:PW-1] == {(PO_W-PW+1){pos_off[PO_W-1]}}) begin
            pos_out = pos_off[PW-1:0];
        end else begin
            pos_out = {pos_off[PO_W-1], {(PW-1){~pos_off[PO_W-1]}}};
        end
        if (nrm_scl[NR_W-1:NW-1] == {(NR_W-NW+1){nrm_scl[NR_W-1]}}) begin
            nrm_out = nrm_scl[NW-1:0];
        end else begin
            nrm_out = {nrm_scl[NR_W-1], {(NW-1){~nrm_scl[NR_W-1]}}};
        end
    end

endmodule

/* hdl/vtb_bounds.sv */
// Running axis-aligned bounding box, one min/max lane per axis.
// Uses vtb_pkg for widths and the control struct.
module vtb_bounds (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vtb_pkg::bnd_ctl_t                 ctl,
    input  logic signed [vtb_pkg::POS_W-1:0]  tp [vtb_pkg::NUM_AXES],
    output logic signed [vtb_pkg::POS_W-1:0]  box_min [vtb_pkg::NUM_AXES],
    output logic signed [vtb_pkg::POS_W-1:0]  box_max [vtb_pkg::NUM_AXES]
);

    logic signed [vtb_pkg::POS_W-1:0] low_reg  [vtb_pkg::NUM_AXES];
    logic signed [vtb_pkg::POS_W-1:0] high_reg [vtb_pkg::NUM_AXES];
    logic signed [vtb_pkg::POS_W-1:0] low_next [vtb_pkg::NUM_AXES];
    logic signed [vtb_pkg::POS_W-1:0] high_next [vtb_pkg::NUM_AXES];

    // Restart or widen each lane
    always_comb begin
        for (int i = 0; i < vtb_pkg::NUM_AXES; i++) begin
            low_next[i]  = low_reg[i];
            high_next[i] = high_reg[i];
            if (ctl.update) begin
                if (ctl.first || tp[i] < low_reg[i]) begin
                    low_next[i] = tp[i];
                end
                if (ctl.first || tp[i] > high_reg[i]) begin
                    high_next[i] = tp[i];
                end
            end
        end
    end

    // Box starts as the point at the origin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vtb_pkg::NUM_AXES; i++) begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign box_min = low_reg;
    assign box_max = high_reg;

endmodule

/* hdl/vertex_transform_bounds.sv */
// Channel  | Handshake            | Word
// ---------+----------------------+---------------------------------------------
// input    | s_valid / s_ready    | position Q16.16 x3, normal Q1.14 x3, first
// result   | m_valid / m_ready    | position x3, normal x3, box min x3, max x3
// config   | cfg_valid/cfg_ready  | cfg_index (register), cfg_data (48 bits)
//
// Two register stages: input register, then result register with the box.
// One word per cycle unless the result stalls; m_valid rises when the result register loads.
// The 16x32 products and three-term sums of the row units set the path.
// Synchronous active-low reset empties both stages and restores identity.
// A stalled result holds while one more word waits in the input register.
//
// Affine vertex transform with bounding box; top level.
// Depends on vtb_pkg, vtb_row_unit and vtb_bounds.
module vertex_transform_bounds (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vtb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vtb_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vtb_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [vtb_pkg::POS_W-1:0]     s_pos_y,
    input  logic signed [vtb_pkg::POS_W-1:0]     s_pos_z,
    input  logic signed [vtb_pkg::NRM_W-1:0]     s_nrm_x,
    input  logic signed [vtb_pkg::NRM_W-1:0]     s_nrm_y,
    input  logic signed [vtb_pkg::NRM_W-1:0]     s_nrm_z,
    input  logic                                 s_first_vertex,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vtb_pkg::POS_W-1:0]     m_out_pos_x,
    output logic signed [vtb_pkg::POS_W-1:0]     m_out_pos_y,
    output logic signed [vtb_pkg::POS_W-1:0]     m_out_pos_z,
    output logic signed [vtb_pkg::NRM_W-1:0]     m_out_nrm_x,
    output logic signed [vtb_pkg::NRM_W-1:0]     m_out_nrm_y,
    output logic signed [vtb_pkg::NRM_W-1:0]     m_out_nrm_z,
    output logic signed [vtb_pkg::POS_W-1:0]     m_box_min_x,
    output logic signed [vtb_pkg::POS_W-1:0]     m_box_min_y,
    output logic signed [vtb_pkg::POS_W-1:0]     m_box_min_z,
    output logic signed [vtb_pkg::POS_W-1:0]     m_box_max_x,
    output logic signed [vtb_pkg::POS_W-1:0]     m_box_max_y,
    output logic signed [vtb_pkg::POS_W-1:0]     m_box_max_z
);

    localparam int NA = vtb_pkg::NUM_AXES;
    localparam int PW = vtb_pkg::POS_W;
    localparam int NW = vtb_pkg::NRM_W;

    // Configuration registers
    logic        [vtb_pkg::ROW_W-1:0] lin_row_reg [NA];
    logic signed [PW-1:0]             trans_reg   [NA];

    // Input stage
    logic                 in_vld_reg;
    logic signed [PW-1:0] pos_reg [NA];
    logic signed [NW-1:0] nrm_reg [NA];
    logic                 first_reg;

    // Result stage
    logic                 out_vld_reg;
    logic signed [PW-1:0] out_pos_reg [NA];
    logic signed [NW-1:0] out_nrm_reg [NA];

    logic                 out_ready;
    logic                 xfer;
    logic                 s_accept;
    logic signed [PW-1:0] tp [NA];
    logic signed [NW-1:0] tn [NA];
    logic signed [PW-1:0] box_min [NA];
    logic signed [PW-1:0] box_max [NA];
    vtb_pkg::bnd_ctl_t    bnd_ctl;

    // Configuration writes, out-of-range indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_row_reg[0] <= vtb_pkg::LIN_ROW0_RST;
            lin_row_reg[1] <= vtb_pkg::LIN_ROW1_RST;
            lin_row_reg[2] <= vtb_pkg::LIN_ROW2_RST;
            for (int i = 0; i < NA; i++) begin
                trans_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vtb_pkg::CFG_LIN_ROW0: lin_row_reg[0] <= cfg_data;
                vtb_pkg::CFG_LIN_ROW1: lin_row_reg[1] <= cfg_data;
                vtb_pkg::CFG_LIN_ROW2: lin_row_reg[2] <= cfg_data;
                vtb_pkg::CFG_TRANS_X:  trans_reg[0]   <= cfg_data[PW-1:0];
                vtb_pkg::CFG_TRANS_Y:  trans_reg[1]   <= cfg_data[PW-1:0];
                vtb_pkg::CFG_TRANS_Z:  trans_reg[2]   <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign out_ready = !out_vld_reg || m_ready;
    assign xfer      = in_vld_reg && out_ready;
    assign s_ready   = !in_vld_reg || out_ready;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_ready) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            nrm_reg[0] <= s_nrm_x;
            nrm_reg[1] <= s_nrm_y;
            nrm_reg[2] <= s_nrm_z;
            first_reg  <= s_first_vertex;
        end
    end

    // One row unit per output axis
    for (genvar r = 0; r < NA; r++) begin : g_row
        vtb_row_unit u_row (
            .coef_row (lin_row_reg[r]),
            .trans    (trans_reg[r]),
            .pos      (pos_reg),
            .nrm      (nrm_reg),
            .pos_out  (tp[r]),
            .nrm_out  (tn[r])
        );
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (xfer) begin
            out_pos_reg <= tp;
            out_nrm_reg <= tn;
        end
    end

    // Box advances together with the result register
    assign bnd_ctl.update = xfer;
    assign bnd_ctl.first  = first_reg;

    vtb_bounds u_bounds (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (bnd_ctl),
        .tp      (tp),
        .box_min (box_min),
        .box_max (box_max)
    );

    assign m_valid     = out_vld_reg;
    assign m_out_pos_x = out_pos_reg[0];
    assign m_out_pos_y = out_pos_reg[1];
    assign m_out_pos_z = out_pos_reg[2];
    assign m_out_nrm_x = out_nrm_reg[0];
    assign m_out_nrm_y = out_nrm_reg[1];
    assign m_out_nrm_z = out_nrm_reg[2];
    assign m_box_min_x = box_min[0];
    assign m_box_min_y = box_min[1];
    assign m_box_min_z = box_min[2];
    assign m_box_max_x = box_max[0];
    assign m_box_max_y = box_max[1];
    assign m_box_max_z = box_max[2];

endmodule

/* hdl/vtb_checker.sv */
// Port-level checks for vertex_transform_bounds, bound to the top level.
// Depends on assert_macros.svh and vtb_pkg.
`include "assert_macros.svh"

module vtb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [vtb_pkg::POS_W-1:0] m_out_pos_x,
    input logic signed [vtb_pkg::POS_W-1:0] m_out_pos_y,
    input logic signed [vtb_pkg::POS_W-1:0] m_out_pos_z,
    input logic signed [vtb_pkg::POS_W-1:0] m_box_min_x,
    input logic signed [vtb_pkg::POS_W-1:0] m_box_min_y,
    input logic signed [vtb_pkg::POS_W-1:0] m_box_min_z,
    input logic signed [vtb_pkg::POS_W-1:0] m_box_max_x,
    input logic signed [vtb_pkg::POS_W-1:0] m_box_max_y,
    input logic signed [vtb_pkg::POS_W-1:0] m_box_max_z
);

    logic box_ordered;
    logic vertex_inside;

    // Corner order and vertex containment, per axis
    assign box_ordered = m_box_min_x <= m_box_max_x &&
                         m_box_min_y <= m_box_max_y &&
                         m_box_min_z <= m_box_max_z;
    assign vertex_inside = m_box_min_x <= m_out_pos_x && m_out_pos_x <= m_box_max_x &&
                           m_box_min_y <= m_out_pos_y && m_out_pos_y <= m_box_max_y &&
                           m_box_min_z <= m_out_pos_z && m_out_pos_z <= m_box_max_z;

    // No result word right out of reset
    `VTB_ASSERT_ALWAYS(a_empty_after_reset, $past(!aresetn) |-> !m_valid, "result after reset")

    // A stalled result word holds
    `VTB_ASSERT(a_hold_stalled, m_valid && !m_ready |=> m_valid && $stable(m_out_pos_x), "stall")

    // Box corners stay ordered
    `VTB_ASSERT(a_box_ordered, m_valid |-> box_ordered, "box corners crossed")

    // The delivered vertex lies inside the delivered box
    `VTB_ASSERT(a_vertex_in_box, m_valid |-> vertex_inside, "vertex outside box")

endmodule

bind vertex_transform_bounds vtb_checker u_vtb_checker (.*);
